[src/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge, off while the kill term is high.
`define BFG_ASSERT(lbl, clk, kill, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (kill) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define BFG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFG_ASSERT(lbl, clk, kill, prop, msg)
`define BFG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[src/bfg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bfg_pkg;

   localparam int FxW      = 24;
   localparam int QuoW     = FxW + 1;
   localparam int ProdW    = 2 * FxW;
   localparam int DivSteps = QuoW;

   typedef enum logic [2:0] {
      MODE_FILL       = 3'd0,
      MODE_CONTAIN    = 3'd1,
      MODE_COVER      = 3'd2,
      MODE_FIT_WIDTH  = 3'd3,
      MODE_FIT_HEIGHT = 3'd4,
      MODE_NONE       = 3'd5,
      MODE_SCALE_DOWN = 3'd6,
      MODE_BAD        = 3'd7
   } mode_type;

   typedef struct packed {
      logic [2:0]     fit_mode;
      logic [3:0]     align_pos;
      logic [FxW-1:0] source_width;
      logic [FxW-1:0] source_height;
      logic [FxW-1:0] target_width;
      logic [FxW-1:0] target_height;
   } req_type;

   typedef struct packed {
      logic [FxW-1:0] crop_x;
      logic [FxW-1:0] crop_y;
      logic [FxW-1:0] crop_width;
      logic [FxW-1:0] crop_height;
      logic [FxW-1:0] place_x;
      logic [FxW-1:0] place_y;
      logic [FxW-1:0] place_width;
      logic [FxW-1:0] place_height;
   } rsp_type;

   // Per-item context that rides along the divider chains
   typedef struct packed {
      mode_type        mode;
      logic [1:0]      ax;
      logic [1:0]      ay;
      logic            zero;
      logic            le;
      logic            ge;
      logic [FxW-1:0]  sw;
      logic [FxW-1:0]  sh;
      logic [FxW-1:0]  dw;
      logic [FxW-1:0]  dh;
      logic [QuoW-1:0] q1;
   } side_type;

   // One divider cell's working set
   typedef struct packed {
      logic [FxW-1:0]  rem;
      logic [QuoW-1:0] quo;
      logic [QuoW-1:0] num;
      logic [FxW-1:0]  den;
      logic            ovf;
      side_type        side;
   } div_type;

   // Column and row ratio codes of the 3x3 grid; off-grid codes center
   function automatic logic [3:0] align_decode(input logic [3:0] pos);
      logic [3:0] r;
      case (pos)
         4'd0:    r = {2'd0, 2'd0};
         4'd1:    r = {2'd1, 2'd0};
         4'd2:    r = {2'd2, 2'd0};
         4'd3:    r = {2'd0, 2'd1};
         4'd4:    r = {2'd1, 2'd1};
         4'd5:    r = {2'd2, 2'd1};
         4'd6:    r = {2'd0, 2'd2};
         4'd7:    r = {2'd1, 2'd2};
         4'd8:    r = {2'd2, 2'd2};
         default: r = {2'd1, 2'd1};
      endcase
      return r;
   endfunction

   // Scale a slack by 0, one half or 1
   function automatic logic [FxW-1:0] align_mul(input logic [FxW-1:0] d,
                                                input logic [1:0] r);
      logic [FxW-1:0] v;
      case (r)
         2'd1:    v = d >> 1;
         2'd2:    v = d;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Quotient, pinned high when the division overflowed
   function automatic logic [QuoW-1:0] div_result(input div_type d);
      return d.ovf ? {QuoW{1'b1}} : d.quo;
   endfunction

   // Load a divider entry from a product and a divisor
   function automatic div_type div_load(input logic [ProdW-1:0] n,
                                        input logic [FxW-1:0] den,
                                        input side_type side);
      div_type d;
      d.rem  = FxW'(n[ProdW-1:QuoW]);
      d.ovf  = FxW'(n[ProdW-1:QuoW]) >= den;
      d.quo  = '0;
      d.num  = n[QuoW-1:0];
      d.den  = den;
      d.side = side;
      return d;
   endfunction

endpackage
`default_nettype wire

[src/box_fit_geometry_unit.sv]
// Box fit geometry unit: fits a source image into a destination box.
// Request channel (req_): one beat carries fit mode, alignment and the
// source and destination sizes, all unsigned 16.8 fixed point.
// Response channel (rsp_): one beat per request with the source crop
// rectangle and the destination placement rectangle.
// The pipeline has 56 register stages: input register, multiply, select, a
// 25-cell quotient chain, multiply, load, a second 25-cell quotient chain
// and the output register. Throughput is one beat per cycle while no
// finished response is stalled; each chain cell resolves one quotient
// bit and hands its partial remainder to the next cell each cycle that
// the pipeline advances.
// When the receiver stalls a waiting response, the whole pipeline holds;
// the input register still takes one more beat if it is empty.
// Reset clears every valid bit; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module box_fit_geometry_unit (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire bfg_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output bfg_pkg::rsp_type     rsp_data
);

   localparam int FxW   = bfg_pkg::FxW;
   localparam int QuoW  = bfg_pkg::QuoW;
   localparam int ProdW = bfg_pkg::ProdW;

   logic advance;

   logic              v0_ff;
   bfg_pkg::req_type  in_ff;
   logic              v1_ff;
   bfg_pkg::side_type side1_ff, side1_in;
   logic [ProdW-1:0]  p1_ff, p2_ff;
   logic              v2_ff;
   bfg_pkg::div_type  d1_ff, d1_in;
   logic              c1_valid;
   bfg_pkg::div_type  c1_data;
   logic              v3_ff;
   bfg_pkg::side_type side3_ff, side3_in;
   logic [ProdW-1:0]  p3_ff;
   logic [FxW-1:0]    den3_ff, den3_in;
   logic [FxW-1:0]    mfac;
   logic [FxW-1:0]    mul_a;
   logic              v4_ff;
   bfg_pkg::div_type  d2_ff;
   logic              c2_valid;
   bfg_pkg::div_type  c2_data;
   logic              rsp_valid_ff;
   bfg_pkg::rsp_type  rsp_ff, rsp_in;

   // Hold everything while a finished beat waits
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = v0_ff && !advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (advance || !v0_ff) begin
         v0_ff <= req_valid;
      end
      if ((advance || !v0_ff) && req_valid) begin
         in_ff <= req_data;
      end
   end

   // Decode mode and alignment
   always_comb begin
      logic [3:0] ratio;
      logic       any_zero;
      ratio    = bfg_pkg::align_decode(in_ff.align_pos);
      any_zero = (in_ff.source_width == '0) || (in_ff.source_height == '0) ||
                 (in_ff.target_width == '0) || (in_ff.target_height == '0);
      side1_in.mode = bfg_pkg::mode_type'(in_ff.fit_mode);
      if (side1_in.mode == bfg_pkg::MODE_SCALE_DOWN) begin
         side1_in.mode = ((in_ff.source_width > in_ff.target_width) ||
                          (in_ff.source_height > in_ff.target_height))
                         ? bfg_pkg::MODE_CONTAIN : bfg_pkg::MODE_NONE;
      end
      side1_in.ax   = ratio[3:2];
      side1_in.ay   = ratio[1:0];
      side1_in.zero = any_zero || (side1_in.mode == bfg_pkg::MODE_BAD);
      side1_in.le   = 1'b0;
      side1_in.ge   = 1'b0;
      side1_in.sw   = in_ff.source_width;
      side1_in.sh   = in_ff.source_height;
      side1_in.dw   = in_ff.target_width;
      side1_in.dh   = in_ff.target_height;
      side1_in.q1   = '0;
   end

   // Cross products dw*sh and dh*sw
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= v0_ff;
      end
      if (advance) begin
         side1_ff <= side1_in;
         p1_ff    <= in_ff.target_width * in_ff.source_height;
         p2_ff    <= in_ff.target_height * in_ff.source_width;
      end
   end

   // Compare and pick the first division
   always_comb begin
      bfg_pkg::side_type s;
      logic [ProdW-1:0]  n;
      logic [FxW-1:0]    den;
      s    = side1_ff;
      s.le = p1_ff <= p2_ff;
      s.ge = p1_ff >= p2_ff;
      case (s.mode)
         bfg_pkg::MODE_CONTAIN: begin
            n   = s.le ? p1_ff : p2_ff;
            den = s.le ? s.sw : s.sh;
         end
         bfg_pkg::MODE_COVER: begin
            n   = s.ge ? p2_ff : p1_ff;
            den = s.ge ? s.dw : s.dh;
         end
         bfg_pkg::MODE_FIT_WIDTH: begin
            n   = p2_ff;
            den = s.dw;
         end
         bfg_pkg::MODE_FIT_HEIGHT: begin
            n   = p1_ff;
            den = s.dh;
         end
         default: begin
            n   = p1_ff;
            den = s.sw;
         end
      endcase
      d1_in = bfg_pkg::div_load(n, den, s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
      if (advance) begin
         d1_ff <= d1_in;
      end
   end

   bfg_div_chain u_div_first (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (v2_ff),
      .in_data   (d1_ff),
      .out_valid (c1_valid),
      .out_data  (c1_data)
   );

   // Clip the first quotient and set up the back-scale product
   always_comb begin
      logic [QuoW-1:0] q;
      q               = bfg_pkg::div_result(c1_data);
      side3_in        = c1_data.side;
      side3_in.q1     = q;
      if (c1_data.side.mode == bfg_pkg::MODE_FIT_HEIGHT) begin
         mfac    = c1_data.side.sw;
         mul_a   = c1_data.side.dh;
         den3_in = c1_data.side.sh;
      end else begin
         mfac    = c1_data.side.sh;
         mul_a   = c1_data.side.dw;
         den3_in = c1_data.side.sw;
      end
      if ({1'b0, mfac} > q) begin
         mfac = FxW'(q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= c1_valid;
      end
      if (advance) begin
         side3_ff <= side3_in;
         den3_ff  <= den3_in;
         p3_ff    <= mfac * mul_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff <= v3_ff;
      end
      if (advance) begin
         d2_ff <= bfg_pkg::div_load(p3_ff, den3_ff, side3_ff);
      end
   end

   bfg_div_chain u_div_second (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (v4_ff),
      .in_data   (d2_ff),
      .out_valid (c2_valid),
      .out_data  (c2_data)
   );

   // Assemble both rectangles
   always_comb begin
      bfg_pkg::side_type s;
      logic [QuoW-1:0]   q1, q2;
      logic [FxW-1:0]    vw, vh, pw, ph, cl;
      s  = c2_data.side;
      q1 = s.q1;
      q2 = bfg_pkg::div_result(c2_data);
      vw = '0;
      vh = '0;
      pw = '0;
      ph = '0;
      cl = '0;
      rsp_in = '0;
      case (s.mode)
         bfg_pkg::MODE_FILL: begin
            rsp_in.crop_width   = s.sw;
            rsp_in.crop_height  = s.sh;
            rsp_in.place_width  = s.dw;
            rsp_in.place_height = s.dh;
         end
         bfg_pkg::MODE_CONTAIN: begin
            pw = s.le ? s.dw : FxW'(q1);
            ph = s.le ? FxW'(q1) : s.dh;
            rsp_in.crop_width   = s.sw;
            rsp_in.crop_height  = s.sh;
            rsp_in.place_x      = bfg_pkg::align_mul(s.dw - pw, s.ax);
            rsp_in.place_y      = bfg_pkg::align_mul(s.dh - ph, s.ay);
            rsp_in.place_width  = pw;
            rsp_in.place_height = ph;
         end
         bfg_pkg::MODE_COVER: begin
            vw = s.ge ? s.sw : FxW'(q1);
            vh = s.ge ? FxW'(q1) : s.sh;
            rsp_in.crop_x       = bfg_pkg::align_mul(s.sw - vw, s.ax);
            rsp_in.crop_y       = bfg_pkg::align_mul(s.sh - vh, s.ay);
            rsp_in.crop_width   = vw;
            rsp_in.crop_height  = vh;
            rsp_in.place_width  = s.dw;
            rsp_in.place_height = s.dh;
         end
         bfg_pkg::MODE_FIT_WIDTH: begin
            cl = ({1'b0, s.sh} > q1) ? FxW'(q1) : s.sh;
            ph = ({1'b0, s.dh} > q2) ? FxW'(q2) : s.dh;
            rsp_in.crop_y       = ({1'b0, s.sh} > q1)
                                  ? bfg_pkg::align_mul(s.sh - FxW'(q1), s.ay) : '0;
            rsp_in.crop_width   = s.sw;
            rsp_in.crop_height  = cl;
            rsp_in.place_y      = bfg_pkg::align_mul(s.dh - ph, s.ay);
            rsp_in.place_width  = s.dw;
            rsp_in.place_height = ph;
         end
         bfg_pkg::MODE_FIT_HEIGHT: begin
            cl = ({1'b0, s.sw} > q1) ? FxW'(q1) : s.sw;
            pw = ({1'b0, s.dw} > q2) ? FxW'(q2) : s.dw;
            rsp_in.crop_x       = ({1'b0, s.sw} > q1)
                                  ? bfg_pkg::align_mul(s.sw - FxW'(q1), s.ax) : '0;
            rsp_in.crop_width   = cl;
            rsp_in.crop_height  = s.sh;
            rsp_in.place_x      = bfg_pkg::align_mul(s.dw - pw, s.ax);
            rsp_in.place_width  = pw;
            rsp_in.place_height = s.dh;
         end
         bfg_pkg::MODE_NONE: begin
            vw = (s.sw < s.dw) ? s.sw : s.dw;
            vh = (s.sh < s.dh) ? s.sh : s.dh;
            rsp_in.crop_x       = bfg_pkg::align_mul(s.sw - vw, s.ax);
            rsp_in.crop_y       = bfg_pkg::align_mul(s.sh - vh, s.ay);
            rsp_in.crop_width   = vw;
            rsp_in.crop_height  = vh;
            rsp_in.place_x      = bfg_pkg::align_mul(s.dw - vw, s.ax);
            rsp_in.place_y      = bfg_pkg::align_mul(s.dh - vh, s.ay);
            rsp_in.place_width  = vw;
            rsp_in.place_height = vh;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
      if (s.zero) begin
         rsp_in = '0;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= c2_valid;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `BFG_ASSERT(a_stall_only_on_backpressure, clock, reset, req_stall |-> (rsp_valid_ff && rsp_stall), "request stalled without response backpressure")
   `BFG_ASSERT(a_hold_output_valid, clock, reset, !advance |=> rsp_valid_ff, "waiting response dropped")
   `BFG_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (!rsp_valid_ff && !v0_ff), "valid bits not cleared by reset")

endmodule
`default_nettype wire

[src/bfg_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module bfg_div_cell (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            advance,
   input  wire logic            in_valid,
   input  wire bfg_pkg::div_type in_data,
   output logic                 out_valid,
   output bfg_pkg::div_type     out_data
);

   logic             valid_ff;
   bfg_pkg::div_type data_ff;
   bfg_pkg::div_type data_in;
   logic [bfg_pkg::FxW:0] trial;
   logic             take;

   // Shift in one numerator bit, subtract the divisor when it fits
   always_comb begin
      trial   = {in_data.rem, in_data.num[bfg_pkg::QuoW-1]};
      take    = trial >= {1'b0, in_data.den};
      data_in = in_data;
      data_in.rem = take ? bfg_pkg::FxW'(trial - {1'b0, in_data.den})
                         : bfg_pkg::FxW'(trial);
      data_in.quo = {in_data.quo[bfg_pkg::QuoW-2:0], take};
      data_in.num = {in_data.num[bfg_pkg::QuoW-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

[src/bfg_div_chain.sv]
`timescale 1ns / 1ps
`default_nettype none
module bfg_div_chain (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            advance,
   input  wire logic            in_valid,
   input  wire bfg_pkg::div_type in_data,
   output logic                 out_valid,
   output bfg_pkg::div_type     out_data
);

   logic             link_valid [bfg_pkg::DivSteps+1];
   bfg_pkg::div_type link_data  [bfg_pkg::DivSteps+1];

   assign link_valid[0] = in_valid;
   assign link_data[0]  = in_data;

   // One quotient bit per cell
   for (genvar i = 0; i < bfg_pkg::DivSteps; i++) begin : g_cell
      bfg_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (link_valid[i]),
         .in_data   (link_data[i]),
         .out_valid (link_valid[i+1]),
         .out_data  (link_data[i+1])
      );
   end

   assign out_valid = link_valid[bfg_pkg::DivSteps];
   assign out_data  = link_data[bfg_pkg::DivSteps];

endmodule
`default_nettype wire

[test/tb_box_fit_geometry_unit.sv]
`timescale 1ns / 1ps
module tb_box_fit_geometry_unit;

   localparam int LATENCY   = 57;
   localparam int WATCHDOG  = 5000;
   localparam int RANDOM_N  = 760;
   localparam logic [23:0] FX_TOP = 24'hFFFFFF;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   bfg_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b1;
   bfg_pkg::rsp_type rsp_data;

   box_fit_geometry_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   // Slack scaled by half the ratio code: 0, one half or 1 for codes 0 to 2
   function automatic logic [63:0] scale_slack(logic [63:0] v, logic [1:0] r);
      return (v * 64'(r)) >> 1;
   endfunction

   function automatic logic [63:0] lesser(logic [63:0] a, logic [63:0] b);
      return a < b ? a : b;
   endfunction

   // Clamp to the 16.8 field range
   function automatic logic [23:0] sat24(logic [63:0] v);
      return (v > 64'(FX_TOP)) ? FX_TOP : v[23:0];
   endfunction

   // Work out the crop and placement rectangles for one request beat
   function automatic bfg_pkg::rsp_type fit_rectangles(bfg_pkg::req_type q);
      bfg_pkg::rsp_type r;
      logic [63:0] sw, sh, dw, dh, a, b, c;
      logic [1:0] ax, ay;
      bfg_pkg::mode_type m;
      r = '0;
      sw = 64'(q.source_width); sh = 64'(q.source_height);
      dw = 64'(q.target_width); dh = 64'(q.target_height);
      m = bfg_pkg::mode_type'(q.fit_mode);
      if (sw == 0 || sh == 0 || dw == 0 || dh == 0 || m == bfg_pkg::MODE_BAD) return r;
      if (q.align_pos <= 4'd8) begin
         ax = 2'(q.align_pos % 4'd3); ay = 2'(q.align_pos / 4'd3);
      end else begin
         ax = 2'd1; ay = 2'd1;
      end
      if (m == bfg_pkg::MODE_SCALE_DOWN)
         m = (sw > dw || sh > dh) ? bfg_pkg::MODE_CONTAIN : bfg_pkg::MODE_NONE;
      case (m)
         bfg_pkg::MODE_FILL: begin
            r.crop_width = sat24(sw); r.crop_height = sat24(sh);
            r.place_width = sat24(dw); r.place_height = sat24(dh);
         end
         bfg_pkg::MODE_CONTAIN: begin
            if (dw * sh <= dh * sw) begin
               a = dw; b = (sh * dw) / sw;
            end else begin
               b = dh; a = (sw * dh) / sh;
            end
            r.crop_width = sat24(sw); r.crop_height = sat24(sh);
            r.place_x = sat24(scale_slack(dw - a, ax));
            r.place_y = sat24(scale_slack(dh - b, ay));
            r.place_width = sat24(a); r.place_height = sat24(b);
         end
         bfg_pkg::MODE_COVER: begin
            if (dw * sh >= dh * sw) begin
               a = sw; b = (dh * sw) / dw;
            end else begin
               b = sh; a = (dw * sh) / dh;
            end
            r.crop_x = sat24(scale_slack(sw - a, ax));
            r.crop_y = sat24(scale_slack(sh - b, ay));
            r.crop_width = sat24(a); r.crop_height = sat24(b);
            r.place_width = sat24(dw); r.place_height = sat24(dh);
         end
         bfg_pkg::MODE_FIT_WIDTH: begin
            a = (dh * sw) / dw;
            b = lesser(sh, a);
            c = lesser(dh, (b * dw) / sw);
            r.crop_y = sh > a ? sat24(scale_slack(sh - a, ay)) : '0;
            r.crop_width = sat24(sw); r.crop_height = sat24(b);
            r.place_y = sat24(scale_slack(dh - c, ay));
            r.place_width = sat24(dw); r.place_height = sat24(c);
         end
         bfg_pkg::MODE_FIT_HEIGHT: begin
            a = (dw * sh) / dh;
            b = lesser(sw, a);
            c = lesser(dw, (b * dh) / sh);
            r.crop_x = sw > a ? sat24(scale_slack(sw - a, ax)) : '0;
            r.crop_width = sat24(b); r.crop_height = sat24(sh);
            r.place_x = sat24(scale_slack(dw - c, ax));
            r.place_width = sat24(c); r.place_height = sat24(dh);
         end
         default: begin
            a = lesser(sw, dw); b = lesser(sh, dh);
            r.crop_x = sat24(scale_slack(sw - a, ax));
            r.crop_y = sat24(scale_slack(sh - b, ay));
            r.crop_width = sat24(a); r.crop_height = sat24(b);
            r.place_x = sat24(scale_slack(dw - a, ax));
            r.place_y = sat24(scale_slack(dh - b, ay));
            r.place_width = sat24(a); r.place_height = sat24(b);
         end
      endcase
      return r;
   endfunction

   class fit_scoreboard;
      bfg_pkg::rsp_type pending_rects[$];
      int               mismatches;

      function void note_request(bfg_pkg::req_type q);
         pending_rects.push_back(fit_rectangles(q));
      endfunction

      function void check_response(bfg_pkg::rsp_type got);
         bfg_pkg::rsp_type want;
         if (pending_rects.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat %h", got);
            return;
         end
         want = pending_rects.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("response mismatch");
               $display("  crop  exp %h %h %h %h got %h %h %h %h",
                  want.crop_x, want.crop_y, want.crop_width, want.crop_height,
                  got.crop_x, got.crop_y, got.crop_width, got.crop_height);
               $display("  place exp %h %h %h %h got %h %h %h %h",
                  want.place_x, want.place_y, want.place_width, want.place_height,
                  got.place_x, got.place_y, got.place_width, got.place_height);
            end
         end
      endfunction
   endclass

   fit_scoreboard board = new();
   bit sender_calm   = 0;   // long stretch without idling
   bit hold_rsp      = 0;   // long receiver hold-off
   int quiet_cycles  = 0;

   // Note accepted beats and check responses
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_request(req_data);
         if (rsp_valid && !rsp_stall) board.check_response(rsp_data);
      end
   end

   // Receiver stall: random, calm, or held off for a long stretch
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b1;
      else if (hold_rsp) rsp_stall <= 1'b1;
      else if (sender_calm) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < 33);
   end

   // Watchdog on cycles with no accepted beat
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [23:0] rand_size();
      case ($urandom_range(7))
         0: return FX_TOP;
         1: return 24'($urandom_range(1, 3));
         2: return 24'($urandom_range(1, 255) << 8);
         3: return 24'($urandom_range(0, 65535));
         default: return 24'($urandom) & FX_TOP;
      endcase
   endfunction

   function automatic bfg_pkg::req_type rand_request();
      bfg_pkg::req_type q;
      q.fit_mode  = 3'($urandom_range(7));
      q.align_pos = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                             : 4'($urandom_range(8));
      q.source_width  = rand_size();
      q.source_height = rand_size();
      q.target_width  = rand_size();
      q.target_height = rand_size();
      if ($urandom_range(19) == 0) begin
         case ($urandom_range(3))
            0: q.source_width = '0;
            1: q.source_height = '0;
            2: q.target_width = '0;
            default: q.target_height = '0;
         endcase
      end
      return q;
   endfunction

   // Offer one beat, with an optional random idle first, and wait for acceptance
   task automatic send_request(bfg_pkg::req_type q, bit may_idle);
      while (may_idle && !sender_calm && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (board.pending_rects.size() != 0) @(posedge clock);
   endtask

   function automatic bfg_pkg::req_type make_req(bfg_pkg::mode_type m, logic [3:0] p,
                                                 logic [23:0] sw, logic [23:0] sh,
                                                 logic [23:0] dw, logic [23:0] dh);
      bfg_pkg::req_type q;
      q.fit_mode = m; q.align_pos = p;
      q.source_width = sw; q.source_height = sh;
      q.target_width = dw; q.target_height = dh;
      return q;
   endfunction

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every mode and alignment, extremes, zero sizes, bad codes
      for (int m = 0; m < 8; m++)
         send_request(make_req(bfg_pkg::mode_type'(m), 4'(m + 1), 24'h012000,
                               24'h008000, 24'h00A000, 24'h00F000), 1'b0);
      send_request(make_req(bfg_pkg::MODE_CONTAIN, 4'd8, FX_TOP, 24'd1, 24'd1, FX_TOP),
                   1'b0);
      send_request(make_req(bfg_pkg::MODE_COVER, 4'd0, 24'd1, FX_TOP, FX_TOP, 24'd1),
                   1'b0);
      send_request(make_req(bfg_pkg::MODE_FIT_WIDTH, 4'd6, FX_TOP, 24'd1, 24'd1, FX_TOP),
                   1'b0);
      send_request(make_req(bfg_pkg::MODE_FIT_HEIGHT, 4'd2, 24'd1, FX_TOP, FX_TOP, 24'd1),
                   1'b0);
      send_request(make_req(bfg_pkg::MODE_NONE, 4'd15, FX_TOP, FX_TOP, 24'd1, 24'd1),
                   1'b0);
      send_request(make_req(bfg_pkg::MODE_SCALE_DOWN, 4'd9, 24'd5, 24'd5, FX_TOP, FX_TOP),
                   1'b0);
      send_request(make_req(bfg_pkg::MODE_SCALE_DOWN, 4'd4, FX_TOP, 24'd5, 24'd7, FX_TOP),
                   1'b0);
      send_request(make_req(bfg_pkg::MODE_FILL, 4'd4, 24'd0, 24'd5, 24'd7, 24'd9), 1'b0);
      send_request(make_req(bfg_pkg::MODE_CONTAIN, 4'd4, 24'd5, 24'd0, 24'd7, 24'd9), 1'b0);
      send_request(make_req(bfg_pkg::MODE_COVER, 4'd4, 24'd5, 24'd5, 24'd0, 24'd9), 1'b0);
      send_request(make_req(bfg_pkg::MODE_NONE, 4'd4, 24'd5, 24'd5, 24'd7, 24'd0), 1'b0);
      send_request(make_req(bfg_pkg::MODE_BAD, 4'd12, FX_TOP, FX_TOP, FX_TOP, FX_TOP),
                   1'b0);
      send_request(make_req(bfg_pkg::MODE_FIT_WIDTH, 4'd7, 24'h003000, 24'h00C000,
                            24'h001000, 24'h002000), 1'b0);
      send_request(make_req(bfg_pkg::MODE_FIT_HEIGHT, 4'd5, 24'h00C000, 24'h003000,
                            24'h002000, 24'h001000), 1'b0);

      // Sender pauses until every result is back
      drain_results();

      // Receiver holds off while the sender keeps offering
      hold_rsp = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 120; i++) send_request(rand_request(), 1'b0);
      join

      for (int i = 0; i < RANDOM_N; i++) begin
         sender_calm = (i >= 300 && i < 450);
         send_request(rand_request(), 1'b1);
      end
      sender_calm = 1'b0;
      drain_results();
      repeat (LATENCY + 10) @(posedge clock);

      if (board.mismatches == 0 && board.pending_rects.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

[sim.f]
+incdir+src
src/bfg_pkg.sv
src/bfg_div_cell.sv
src/bfg_div_chain.sv
src/box_fit_geometry_unit.sv
test/tb_box_fit_geometry_unit.sv
